// File: sv/kmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

  localparam int MAX_LEN_DEFAULT = 1024;
  localparam int SYM_W = 8;
  localparam int OUT_W = 10;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             start_req;
  } sym_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] prefix_length;
    logic [OUT_W-1:0] position;
    logic             overflow;
  } pf_item_t;

  typedef logic [1:0] step_t;

  localparam step_t STEP_WAIT  = 2'd0;
  localparam step_t STEP_FETCH = 2'd1;
  localparam step_t STEP_TEST  = 2'd2;
  localparam step_t STEP_LINK  = 2'd3;

  typedef enum logic [1:0] {
    COND_ALWAYS  = 2'd0,
    COND_NO_ITEM = 2'd1,
    COND_DONE    = 2'd2
  } cond_t;

  typedef enum logic [1:0] {
    FIN_NONE  = 2'd0,
    FIN_EARLY = 2'd1,
    FIN_TEST  = 2'd2
  } fin_t;

  typedef struct packed {
    logic  take_in;
    logic  rd_char;
    logic  rd_link;
    logic  ld_k;
    fin_t  fin;
    cond_t cond;
    step_t jump;
    step_t next;
  } ucode_t;

  typedef struct packed {
    logic item;
    logic done;
    logic slot_free;
  } useq_stat_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '0;
    unique case (step)
      STEP_WAIT: begin
        w.take_in = 1'b1;
        w.fin     = FIN_NONE;
        w.cond    = COND_NO_ITEM;
        w.jump    = STEP_WAIT;
        w.next    = STEP_FETCH;
      end
      STEP_FETCH: begin
        w.rd_char = 1'b1;
        w.fin     = FIN_EARLY;
        w.cond    = COND_DONE;
        w.jump    = STEP_WAIT;
        w.next    = STEP_TEST;
      end
      STEP_TEST: begin
        w.rd_link = 1'b1;
        w.fin     = FIN_TEST;
        w.cond    = COND_DONE;
        w.jump    = STEP_WAIT;
        w.next    = STEP_LINK;
      end
      STEP_LINK: begin
        w.ld_k    = 1'b1;
        w.fin     = FIN_NONE;
        w.cond    = COND_ALWAYS;
        w.jump    = STEP_FETCH;
        w.next    = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: sv/kmp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kmp_sym_if;
  logic              valid;
  logic              ready;
  kmp_pkg::sym_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kmp_pf_if;
  logic             valid;
  logic             ready;
  kmp_pkg::pf_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/kmp_useq.sv
`timescale 1ns / 1ps
`default_nettype none

module kmp_useq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kmp_pkg::useq_stat_t stat,
  output kmp_pkg::ucode_t          ctl
);

  kmp_pkg::step_t step;
  kmp_pkg::step_t step_next;
  logic           taken;
  logic           hold;

  assign ctl = kmp_pkg::ucode_rom(step);

  always_comb begin
    unique case (ctl.cond)
      kmp_pkg::COND_ALWAYS:  taken = 1'b1;
      kmp_pkg::COND_NO_ITEM: taken = !stat.item;
      kmp_pkg::COND_DONE:    taken = stat.done && stat.slot_free;
      default:               taken = 1'b0;
    endcase
  end

  // A finished item waits here while the output register is still full.
  assign hold = (ctl.cond == kmp_pkg::COND_DONE) && stat.done && !stat.slot_free;

  always_comb begin
    if (hold) begin
      step_next = step;
    end else if (taken) begin
      step_next = ctl.jump;
    end else begin
      step_next = ctl.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= kmp_pkg::STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/kmp_prefix_function_stream.sv
// Streaming prefix-function unit for the Knuth-Morris-Pratt algorithm.
// Characters arrive on the chars channel, one per item, with start_req set
// on the first character of each new string. For every character one item
// leaves on the prefixes channel: the prefix value, the character's position
// and an overflow flag. Characters past MAX_LEN in one string are not stored;
// their items carry overflow set and zero in the other fields.
// The block works on one character at a time under a four-step microprogram.
// A character is accepted in the wait step. The fetch step reads the character
// memory, but finishes at once for the first character of a string and for an
// overflowing one; the test step compares and reads the prefix memory. Each
// failure link that is followed adds the link step and one more pass through the
// character and prefix memory read ports. Reset clears the matched length, the
// position and the output valid flag; the memories keep their contents, and a new
// string only reads entries it has written itself. While the receiver stalls, the
// next character is still accepted and processed up to its result, and then
// waits until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module kmp_prefix_function_stream #(
  parameter int MAX_LEN = kmp_pkg::MAX_LEN_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  kmp_sym_if.sink   chars,
  kmp_pf_if.source  prefixes
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int OW = kmp_pkg::OUT_W;
  localparam int SW = kmp_pkg::SYM_W;

  logic [SW-1:0] char_store [MAX_LEN];
  logic [AW-1:0] prefix_store [MAX_LEN];

  kmp_pkg::ucode_t     ctl;
  kmp_pkg::useq_stat_t stat;

  logic [SW-1:0] sym;
  logic [AW-1:0] k;
  logic [AW-1:0] ml;
  logic [PW-1:0] np;
  logic [AW-1:0] pos;
  logic          ovf;
  logic [SW-1:0] char_rd;
  logic [AW-1:0] link_rd;

  logic          accept;
  logic [PW-1:0] base_np;
  logic          hit;
  logic          done;
  logic          slot_free;
  logic          fire;
  logic          write;
  logic [AW-1:0] result_k;

  kmp_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  assign chars.ready = ctl.take_in;
  assign accept      = chars.valid && chars.ready;
  assign base_np     = chars.data.start_req ? '0 : np;
  assign slot_free   = !prefixes.valid || prefixes.ready;
  assign hit         = (char_rd == sym);

  always_comb begin
    unique case (ctl.fin)
      kmp_pkg::FIN_EARLY: done = ovf || (pos == '0);
      kmp_pkg::FIN_TEST:  done = hit || (k == '0);
      default:            done = 1'b0;
    endcase
  end

  assign result_k = ((ctl.fin == kmp_pkg::FIN_TEST) && hit) ? k + AW'(1) : '0;
  assign fire     = done && slot_free;
  assign write    = fire && !ovf;

  assign stat.item      = accept;
  assign stat.done      = done;
  assign stat.slot_free = slot_free;

  always_ff @(posedge clk) begin
    if (accept) begin
      sym <= chars.data.symbol;
      ovf <= (base_np == PW'(MAX_LEN));
      pos <= AW'(base_np);
      k   <= chars.data.start_req ? '0 : ml;
    end else if (ctl.ld_k) begin
      k <= link_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      char_store[pos] <= sym;
    end
    if (ctl.rd_char) begin
      char_rd <= char_store[k];
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      prefix_store[pos] <= result_k;
    end
    if (ctl.rd_link) begin
      link_rd <= prefix_store[k - AW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ml <= '0;
      np <= '0;
    end else if (write) begin
      ml <= result_k;
      np <= PW'(pos) + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefixes.valid <= 1'b0;
    end else if (fire) begin
      prefixes.valid <= 1'b1;
    end else if (prefixes.ready) begin
      prefixes.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      prefixes.data.prefix_length <= ovf ? '0 : OW'(result_k);
      prefixes.data.position      <= ovf ? '0 : OW'(pos);
      prefixes.data.overflow      <= ovf;
    end
  end

endmodule

`default_nettype wire

// File: bench/kmp_prefix_check.sv
`timescale 1ns / 1ps

module kmp_prefix_check #(
  parameter int MAX_LEN = kmp_pkg::MAX_LEN_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  kmp_sym_if       chars_mon,
  kmp_pf_if        pf_mon,
  output int       errors,
  output int       pending
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = AW + 1;
  localparam int OW = kmp_pkg::OUT_W;

  logic [kmp_pkg::SYM_W-1:0] seen_chars [MAX_LEN];
  logic [AW-1:0]             prefix_vals [MAX_LEN];
  logic [AW-1:0]             matched;
  logic [PW-1:0]             next_pos;
  kmp_pkg::pf_item_t         expected_prefixes [$];
  kmp_pkg::pf_item_t         want;

  initial begin
    for (int i = 0; i < MAX_LEN; i++) begin
      seen_chars[i] = '0;
      prefix_vals[i] = '0;
    end
  end

  function automatic kmp_pkg::pf_item_t next_prefix_value(input kmp_pkg::sym_item_t it);
    logic [PW-1:0]     pos;
    logic [AW-1:0]     k;
    logic [AW-1:0]     back;
    kmp_pkg::pf_item_t r;
    r = '0;
    if (it.start_req) begin
      matched = '0;
      next_pos = '0;
    end
    pos = next_pos;
    if (int'(pos) >= MAX_LEN) begin
      r.overflow = 1'b1;
      return r;
    end
    seen_chars[pos[AW-1:0]] = it.symbol;
    k = '0;
    if (pos != '0) begin
      k = matched;
      if ({1'b0, k} >= pos) k = '0;
      while (k != '0 && seen_chars[k] != it.symbol) begin
        back = prefix_vals[k - AW'(1)];
        k = (back < k) ? back : '0;
      end
      if (seen_chars[k] == it.symbol) k = k + AW'(1);
    end
    prefix_vals[pos[AW-1:0]] = k;
    matched = k;
    next_pos = pos + PW'(1);
    r.prefix_length = OW'(k);
    r.position = OW'(pos[AW-1:0]);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      matched = '0;
      next_pos = '0;
      expected_prefixes.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (pf_mon.valid && pf_mon.ready) begin
        if (expected_prefixes.size() == 0) begin
          $error("unexpected prefix item: prefix_length %0d position %0d overflow %0d",
                 pf_mon.data.prefix_length, pf_mon.data.position, pf_mon.data.overflow);
          errors++;
        end else begin
          want = expected_prefixes.pop_front();
          if (pf_mon.data.prefix_length !== want.prefix_length) begin
            $error("prefix_length: expected %0d, got %0d",
                   want.prefix_length, pf_mon.data.prefix_length);
            errors++;
          end
          if (pf_mon.data.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, pf_mon.data.position);
            errors++;
          end
          if (pf_mon.data.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, pf_mon.data.overflow);
            errors++;
          end
        end
      end
      if (chars_mon.valid && chars_mon.ready) begin
        expected_prefixes.insert(expected_prefixes.size(), next_prefix_value(chars_mon.data));
      end
      pending = expected_prefixes.size();
    end
  end

endmodule

// File: bench/tb_kmp_prefix_function_stream.sv
`timescale 1ns / 1ps

module tb_kmp_prefix_function_stream;

  localparam int LEN_CAP = 1024;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   items_sent;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_req;
  bit   hold_taken;
  int   quiet_cycles;

  kmp_sym_if chars_if ();
  kmp_pf_if  pf_if ();

  kmp_prefix_function_stream #(.MAX_LEN(LEN_CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars_if),
    .prefixes (pf_if)
  );

  kmp_prefix_check #(.MAX_LEN(LEN_CAP)) chk (
    .clk       (clk),
    .rst       (rst),
    .chars_mon (chars_if),
    .pf_mon    (pf_if),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    pf_if.ready = 1'b0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        pf_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pf_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((chars_if.valid && chars_if.ready) ||
          (pf_if.valid && pf_if.ready && pending > 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("kmp_prefix_function_stream regression: fail");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [kmp_pkg::SYM_W-1:0] sym, input logic st);
    kmp_pkg::sym_item_t it;
    it.symbol = sym;
    it.start_req = st;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.data <= it;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == 0);
  endtask

  task automatic send_text(input int len, input int alpha);
    logic [kmp_pkg::SYM_W-1:0] base;
    base = kmp_pkg::SYM_W'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      send_item(base + kmp_pkg::SYM_W'($urandom_range(0, alpha - 1)), i == 0);
    end
  endtask

  task automatic send_periodic(input int len, input int period, input int mut_pct,
                               input int mut_span);
    logic [kmp_pkg::SYM_W-1:0] base;
    logic [kmp_pkg::SYM_W-1:0] pat [8];
    logic [kmp_pkg::SYM_W-1:0] sym;
    base = kmp_pkg::SYM_W'($urandom_range(0, 255));
    for (int i = 0; i < 8; i++) pat[i] = base + kmp_pkg::SYM_W'($urandom_range(0, 2));
    for (int i = 0; i < len; i++) begin
      sym = pat[i % period];
      if (i < mut_span && $urandom_range(0, 99) < mut_pct) begin
        sym = base + kmp_pkg::SYM_W'($urandom_range(0, 3));
      end
      send_item(sym, i == 0);
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(kmp_pkg::SYM_W'($urandom_range(0, 255)), $urandom_range(0, 99) < 20);
    end
  endtask

  task automatic send_mix(input int count);
    int target;
    int kind;
    target = items_sent + count;
    while (items_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) send_text($urandom_range(1, 30), $urandom_range(1, 4));
      else if (kind < 8) send_periodic($urandom_range(4, 60), $urandom_range(1, 6), 5, 1000);
      else if (kind == 8) send_text($urandom_range(1, 20), 256);
      else send_noise($urandom_range(1, 10));
    end
  endtask

  initial begin
    rst = 1'b1;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    chars_if.valid = 1'b0;
    chars_if.data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // The first string after reset carries no start request.
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b0);
    send_word("abcabd");
    send_word("aaaab");

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 54; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 54; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      send_mix(90);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    send_mix(40);

    // One string runs past capacity; a start request then recovers.
    send_idle_pct = 11;
    recv_stall_pct = 11;
    send_periodic(LEN_CAP + 6, $urandom_range(3, 7), 2, 100);
    send_item(kmp_pkg::SYM_W'($urandom_range(0, 255)), 1'b1);
    send_item(kmp_pkg::SYM_W'($urandom_range(0, 255)), 1'b0);
    send_mix(20);

    chars_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("kmp_prefix_function_stream regression: pass");
    end else begin
      $display("kmp_prefix_function_stream regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/kmp_pkg.sv
sv/kmp_if.sv
sv/kmp_useq.sv
sv/kmp_prefix_function_stream.sv
bench/kmp_prefix_check.sv
bench/tb_kmp_prefix_function_stream.sv
